/* rtl/lrtt_pkg.sv */
package lrtt_pkg;

  // fixed field widths
  localparam int unsigned IdxW     = 10;
  localparam int unsigned StampW   = 64;
  localparam int unsigned CountW   = 64;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 80;   // index + stamp, padded to bytes
  localparam int unsigned OutDataW = 144;  // echo + total + count, padded to bytes
  localparam int unsigned OutUserW = 3;
  localparam int unsigned ProdW    = 2 * StampW;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_ENTRY = 2'd0,
    CMD_EXIT  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_INTERVAL  = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_FREQ      = 2'd3
  } cfg_idx_e;

  localparam logic [CfgW-1:0] RstInterval  = 32'd100;
  localparam logic [CfgW-1:0] RstThreshold = 32'd800;
  localparam logic [CfgW-1:0] RstFreq      = 32'd2200000000;

  // cycles to microseconds scale
  localparam logic [StampW-1:0] MicroScale = 64'd1000000;

  // remainder unit runs one dividend bit per cycle
  localparam logic [5:0] LastDivBit = 6'd63;
  // partial products per wide multiply
  localparam logic [2:0] MulSteps   = 3'd4;

  // one region slot as held in the table memory
  typedef struct packed {
    logic              off;
    logic [CountW-1:0] tally;
    logic [CountW-1:0] total;
    logic [StampW-1:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_RATE,
    S_RHS,
    S_LHS,
    S_RESP
  } state_e;

endpackage

/* rtl/lrtt_ram.sv */
module lrtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lrtt_mul.sv */
module lrtt_mul import lrtt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [StampW-1:0] a_i,
  input  logic [StampW-1:0] b_i,
  output logic              done_o,
  output logic [ProdW-1:0]  prod_o
);

  // 64x64 product from four 32x32 partial products, one per cycle
  logic [StampW-1:0] a_q, b_q;
  logic [ProdW-1:0]  acc_q;
  logic [StampW-1:0] pp_q;
  logic [1:0]        sh_q;
  logic [2:0]        cnt_q;
  logic              busy_q, pp_vld_q, done_q;

  logic [31:0] a_half, b_half;
  logic [1:0]  sh_sel;

  assign a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
  assign sh_sel = 2'(cnt_q[0]) + 2'(cnt_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        if (cnt_q != MulSteps) begin
          pp_vld_q <= 1'b1;
          cnt_q    <= cnt_q + 3'd1;
        end else begin
          pp_vld_q <= 1'b0;
        end
        if (pp_vld_q && cnt_q == MulSteps) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (busy_q && cnt_q != MulSteps) begin
        pp_q <= 64'(a_half) * 64'(b_half);
        sh_q <= sh_sel;
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + (ProdW'(pp_q) << {sh_q, 5'd0});
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/loop_region_timer_table.sv */
// region timer table
// input stream: one beat per command; tuser carries the command (entry, exit,
// read), tdata the region index and the current timestamp. output stream: one
// beat per input beat, in order, with the region's totals after the command
// and three flags in tuser. configuration is a separate write channel that is
// always ready and should only be used while no command is in flight.
// per-region state (start stamp, cycle total, entry count, shut-off mark)
// sits in one single-port-write table memory; each command is a
// read-modify-write of its slot, one command at a time.
// entry, read and dropped commands pass from accept through the slot read to
// the result beat, and the next command is accepted only after that result is
// loaded; an index outside the table skips the slot read. an exit with the
// check enabled and a nonzero count first runs a bit-serial remainder of the
// count by the check interval; when the count is a multiple, three wide
// products on a shared 32x32 multiplier follow.
// after reset the table is swept to zero with the input held not ready. the
// result sits in an output register, so a stalled receiver only holds back the
// next command once that one is finished too.
module loop_region_timer_table import lrtt_pkg::*; #(
  parameter int unsigned REGION_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // region_index, stamp, zero pad
  input  logic [CmdW-1:0]     s_axis_tuser,   // cmd
  // result beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // region_echo, total_cycles,
                                              // visit_count, zero pad
  output logic [OutUserW-1:0] m_axis_tuser,   // is_shut_off, shutoff_event, ignored
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam logic [16:0] RegionLimit = 17'(REGION_COUNT);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(REGION_COUNT - 1);

  // configuration registers
  logic            en_q;
  logic [CfgW-1:0] interval_q, threshold_q, freq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      interval_q  <= RstInterval;
      threshold_q <= RstThreshold;
      freq_q      <= RstFreq;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:    en_q        <= cfg_data_i[0];
        CFG_INTERVAL:  interval_q  <= cfg_data_i;
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_FREQ:      freq_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input beat fields
  logic [IdxW-1:0]   in_idx;
  logic [StampW-1:0] in_stamp;
  logic              in_range;
  logic              s_accept;

  assign in_idx   = s_axis_tdata[IdxW-1:0];
  assign in_stamp = s_axis_tdata[IdxW+StampW-1:IdxW];
  assign in_range = 17'(in_idx) < RegionLimit;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // control and working registers
  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_addr_q;
  cmd_e              cmd_q;
  logic [IdxW-1:0]   idx_q;
  logic [StampW-1:0] now_q;
  entry_t            ent_q;
  logic              evt_q, ign_q;
  logic [CfgW-1:0]   rem_q;
  logic [CountW-1:0] div_q;
  logic [5:0]        bit_q;
  logic [ProdW-1:0]  rhs_q;

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic                out_load;

  // table memory
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           rd;
  logic [EntryW-1:0] ram_rdata;

  lrtt_ram #(
    .Width (EntryW),
    .Depth (REGION_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s_accept),
    .raddr_i (AddrW'(in_idx)),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // shared wide multiplier
  logic              mul_start, mul_done;
  logic [StampW-1:0] mul_a, mul_b;
  logic [ProdW-1:0]  mul_prod;

  lrtt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // slot update for the command just read
  logic   is_move;      // entry or exit
  logic   drop;         // entry or exit on a region already shut off
  logic   check_go;     // exit that may trigger the average check
  entry_t exec_new;

  assign is_move = (cmd_q == CMD_ENTRY) || (cmd_q == CMD_EXIT);
  assign drop    = is_move && rd.off;

  always_comb begin
    exec_new = rd;
    if (cmd_q == CMD_ENTRY) begin
      exec_new.stamp = now_q;
      exec_new.tally = rd.tally + 64'd1;
    end else begin
      exec_new.total = rd.total + (now_q - rd.stamp);
    end
  end

  assign check_go = (cmd_q == CMD_EXIT) && en_q && (interval_q != '0) && (rd.tally != '0);

  // bit-serial remainder step: count mod check interval
  logic [CfgW:0]   rem_sh;
  logic [CfgW-1:0] rem_nx;

  assign rem_sh = {rem_q, div_q[CountW-1]};
  assign rem_nx = (rem_sh >= {1'b0, interval_q}) ? CfgW'(rem_sh - {1'b0, interval_q})
                                                 : rem_sh[CfgW-1:0];

  // average check: total * 1e6 < threshold * freq * count
  logic below;
  assign below = mul_prod < rhs_q;

  assign out_load = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = 64'(threshold_q);
    mul_b     = 64'(freq_q);
    ram_we    = 1'b0;
    ram_waddr = AddrW'(idx_q);
    ram_wdata = exec_new;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
        if (clr_addr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          state_d = in_range ? S_EXEC : S_RESP;
        end
      end
      S_EXEC: begin
        if (is_move && !drop) begin
          ram_we = 1'b1;
        end
        state_d = (!drop && check_go) ? S_MOD : S_RESP;
      end
      S_MOD: begin
        if (bit_q == LastDivBit) begin
          if (rem_nx == '0) begin
            mul_start = 1'b1;
            state_d   = S_RATE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_RATE: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod[StampW-1:0];
          mul_b     = ent_q.tally;
          state_d   = S_RHS;
        end
      end
      S_RHS: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = ent_q.total;
          mul_b     = MicroScale;
          state_d   = S_LHS;
        end
      end
      S_LHS: begin
        if (mul_done) begin
          ram_wdata     = ent_q;
          ram_wdata.off = 1'b1;
          ram_we        = below;
          state_d       = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          cmd_q <= cmd_e'(s_axis_tuser);
          idx_q <= in_idx;
          now_q <= in_stamp;
          evt_q <= 1'b0;
          ign_q <= !in_range;
          ent_q <= '0;
        end
      end
      S_EXEC: begin
        ign_q <= drop;
        ent_q <= (is_move && !drop) ? exec_new : rd;
        rem_q <= '0;
        div_q <= rd.tally;
        bit_q <= '0;
      end
      S_MOD: begin
        rem_q <= rem_nx;
        div_q <= {div_q[CountW-2:0], 1'b0};
        bit_q <= bit_q + 6'd1;
      end
      S_RHS: begin
        if (mul_done) begin
          rhs_q <= mul_prod;
        end
      end
      S_LHS: begin
        if (mul_done && below) begin
          ent_q.off <= 1'b1;
          evt_q     <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RESP && out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_load) begin
      out_data_q <= OutDataW'({ent_q.tally, ent_q.total, idx_q});
      out_user_q <= {ign_q, evt_q, ent_q.off};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  // an accepted beat goes straight to the slot read or to the out-of-range reply
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_EXEC || state_q == S_RESP))
    else $error("accepted beat not followed by slot update or reply");

  // multiplier results only arrive while the check sequence waits for them
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_RATE || state_q == S_RHS || state_q == S_LHS))
    else $error("multiplier finished outside the check sequence");

  // a shut-off event always reports the region as shut off
  a_event_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("shut-off event without shut-off mark");

  // the table is never written while waiting for a command or handing over a result
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE && state_q != S_RESP))
    else $error("table write outside an update state");
`endif

endmodule

/* tb/tb_loop_region_timer_table.sv */
module tb_loop_region_timer_table import lrtt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Regions    = 1024;
  localparam int          DirRows    = 23;
  // long receiver hold-off, enough to back the command stream up
  localparam int          HoldCycles = 300;
  localparam int          HoldAfter  = 450;
  // unused command code, behaves as a read
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;

  // one result beat, unpacked
  typedef struct packed {
    logic [IdxW-1:0]   echo;
    logic [CountW-1:0] total;
    logic [CountW-1:0] count;
    logic              off;
    logic              evt;
    logic              ign;
  } res_t;

  // one directed row: seg selects the settings the row runs under
  typedef struct packed {
    logic              seg;
    logic [CmdW-1:0]   cmd;
    logic [IdxW-1:0]   idx;
    logic [StampW-1:0] stamp;
    logic              typed;
    res_t              want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [CmdW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  loop_region_timer_table #(
    .REGION_COUNT(Regions)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow copy of the region table and the settings
  bit   [StampW-1:0] sh_stamp [Regions];
  bit   [CountW-1:0] sh_total [Regions];
  bit   [CountW-1:0] sh_tally [Regions];
  bit                sh_off   [Regions];
  bit                sh_en    = 1'b0;
  logic [CfgW-1:0]   sh_ival  = RstInterval;
  logic [CfgW-1:0]   sh_thr   = RstThreshold;
  logic [CfgW-1:0]   sh_freq  = RstFreq;

  // stimulus-side view of which regions have an open visit
  bit                visit_open [Regions];
  logic [StampW-1:0] visit_start [Regions];
  logic [StampW-1:0] tick;
  int                next_base;

  res_t pending_totals [$];
  int   in_beats   = 0;
  int   out_beats  = 0;
  int   mismatches = 0;
  res_t got, want;

  // directed rows; typed expectations only where they are obvious
  row_t dir_rows [DirRows] = '{
    // fresh table reads back empty, spare command reads too
    '{0, CMD_READ,  0,    64'd0,                  1, '{0,    0,   0, 0, 0, 0}},
    '{0, CmdSpare,  1023, 64'hFFFF_FFFF_FFFF_FFFF, 1, '{1023, 0,   0, 0, 0, 0}},
    // top region, stamp at its ceiling, then an exit that wraps round
    '{0, CMD_ENTRY, 1023, 64'hFFFF_FFFF_FFFF_FFFF, 1, '{1023, 0,   1, 0, 0, 0}},
    '{0, CMD_EXIT,  1023, 64'd0,                  1, '{1023, 1,   1, 0, 0, 0}},
    // exit with no entry measures from the cleared stamp
    '{0, CMD_EXIT,  7,    64'd100,                1, '{7,    100, 0, 0, 0, 0}},
    // alternating bit patterns on index and stamp
    '{0, CMD_ENTRY, 341,  64'h5555_5555_5555_5555, 1, '{341,  0,   1, 0, 0, 0}},
    '{0, CMD_EXIT,  341,  64'hAAAA_AAAA_AAAA_AAAA, 0, '0},
    '{0, CmdSpare,  341,  64'hAAAA_AAAA_AAAA_AAAA, 0, '0},
    // elapsed time of all ones, then the total wraps past zero
    '{0, CMD_ENTRY, 682,  64'h8000_0000_0000_0000, 0, '0},
    '{0, CMD_EXIT,  682,  64'h7FFF_FFFF_FFFF_FFFF, 0, '0},
    '{0, CMD_ENTRY, 682,  64'd0,                  0, '0},
    '{0, CMD_EXIT,  682,  64'd2,                  0, '0},
    '{0, CMD_READ,  682,  64'h0123_4567_89AB_CDEF, 0, '0},
    // zero elapsed time
    '{0, CMD_ENTRY, 512,  64'd0,                  0, '0},
    '{0, CMD_EXIT,  512,  64'd0,                  1, '{512,  0,   1, 0, 0, 0}},
    // check enabled, interval one, widest threshold:
    // exit at zero count stays on, the next visit shuts the region off
    '{1, CMD_EXIT,  200,  64'd50,                 1, '{200,  50,  0, 0, 0, 0}},
    '{1, CMD_ENTRY, 200,  64'd60,                 1, '{200,  50,  1, 0, 0, 0}},
    '{1, CMD_EXIT,  200,  64'd70,                 1, '{200,  60,  1, 1, 1, 0}},
    '{1, CMD_ENTRY, 200,  64'd80,                 1, '{200,  60,  1, 1, 0, 1}},
    '{1, CMD_EXIT,  200,  64'd90,                 1, '{200,  60,  1, 1, 0, 1}},
    '{1, CMD_READ,  200,  64'd0,                  1, '{200,  60,  1, 1, 0, 0}},
    // longest possible visit stays above any threshold
    '{1, CMD_ENTRY, 201,  64'd0,                  0, '0},
    '{1, CMD_EXIT,  201,  64'hFFFF_FFFF_FFFF_FFFF, 0, '0}
  };

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // no idling on either side while this window of beats goes through
  function automatic bit steady_window();
    return in_beats >= 700 && in_beats < 850;
  endfunction

  // apply one command to the shadow table, return the result it gives
  function automatic res_t advance_region(input logic [CmdW-1:0] c,
                                          input logic [IdxW-1:0] r,
                                          input logic [StampW-1:0] now);
    res_t              o;
    logic [CountW-1:0] cnt;
    logic [2*CfgW-1:0] rate;
    logic [ProdW-1:0]  lhs;
    logic [ProdW-1:0]  rhs;
    o = '0;
    o.echo = r;
    if (c == CMD_ENTRY || c == CMD_EXIT) begin
      if (sh_off[r]) begin
        o.ign = 1'b1;
      end else if (c == CMD_ENTRY) begin
        sh_stamp[r] = now;
        sh_tally[r] = sh_tally[r] + 1;
      end else begin
        sh_total[r] = sh_total[r] + (now - sh_stamp[r]);
        cnt  = sh_tally[r];
        // exact compare: total * 1e6 < threshold * freq * count
        rate = {32'd0, sh_thr} * {32'd0, sh_freq};
        lhs  = {64'd0, sh_total[r]} * {64'd0, MicroScale};
        rhs  = {64'd0, rate} * {64'd0, cnt};
        if (sh_en && sh_ival != 0 && cnt != 0 && (cnt % {32'd0, sh_ival}) == 0 &&
            lhs < rhs) begin
          sh_off[r] = 1'b1;
          o.evt     = 1'b1;
        end
      end
    end
    o.total = sh_total[r];
    o.count = sh_tally[r];
    o.off   = sh_off[r];
    return o;
  endfunction

  // offer one command beat; returns on the falling edge after acceptance
  task automatic send_cmd(input logic [CmdW-1:0] c, input logic [IdxW-1:0] r,
                          input logic [StampW-1:0] st, input logic typed,
                          input res_t typed_want);
    res_t pred;
    while (!steady_window() && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {{(InDataW - IdxW - StampW){1'b0}}, st, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    in_beats++;
    pred = advance_region(c, r, st);
    pending_totals.push_back(typed ? typed_want : pred);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e i, input logic [CfgW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= i;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (i)
      CFG_ENABLE:    sh_en   = d[0];
      CFG_INTERVAL:  sh_ival = d;
      CFG_THRESHOLD: sh_thr  = d;
      CFG_FREQ:      sh_freq = d;
      default:       ;
    endcase
    @(negedge clk_i);
  endtask

  // let the table go quiet, then load a full set of settings
  task automatic settle_and_configure(input logic [CfgW-1:0] en_word, ival, thr, freq);
    s_axis_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    // a spare wait so the last command is fully retired
    repeat (8) @(negedge clk_i);
    cfg_write(CFG_ENABLE, en_word);
    cfg_write(CFG_INTERVAL, ival);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_FREQ, freq);
    cfg_valid_i <= 1'b0;
  endtask

  // random phase: mostly entry/exit pairs over a window of fresh regions,
  // with reads and unrelated noise mixed in
  task automatic run_phase(input logic [CfgW-1:0] en_word, ival, thr, freq,
                           input int n_items, input int window,
                           input int unsigned short_max, input int big_pct);
    int                k;
    int                roll;
    logic [CmdW-1:0]   c;
    logic [IdxW-1:0]   r;
    logic [StampW-1:0] st;
    logic [StampW-1:0] span;
    settle_and_configure(en_word, ival, thr, freq);
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      r    = IdxW'((next_base + $urandom_range(window - 1)) % Regions);
      if (roll < 12) begin
        // noise: any command, any region, any stamp
        c  = CmdW'($urandom_range(3));
        r  = IdxW'($urandom_range(Regions - 1));
        st = {$urandom, $urandom};
      end else if (roll < 20) begin
        c  = $urandom_range(1) ? CMD_READ : CmdSpare;
        st = {$urandom, $urandom};
      end else if (!visit_open[r]) begin
        c              = CMD_ENTRY;
        st             = tick;
        visit_start[r] = tick;
        visit_open[r]  = 1'b1;
      end else begin
        if ($urandom_range(99) < big_pct)
          span = $urandom_range(1) ? {32'd0, $urandom} : {$urandom, $urandom};
        else
          span = StampW'($urandom_range(short_max));
        c             = CMD_EXIT;
        st            = visit_start[r] + span;
        visit_open[r] = 1'b0;
      end
      tick = tick + StampW'($urandom_range(5000, 1));
      send_cmd(c, r, st, 1'b0, '0);
    end
    next_base += window;
  endtask

  // stimulus and configuration
  initial begin
    int  i;
    logic prev_seg;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ENTRY;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ENABLE;
    cfg_data_i    = '0;
    tick          = {$urandom, $urandom};
    next_base     = 8;
    prev_seg      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset settings first
    for (i = 0; i < DirRows; i++) begin
      if (dir_rows[i].seg != prev_seg) begin
        settle_and_configure(32'd1, 32'd1, '1, '1);
        prev_seg = dir_rows[i].seg;
      end
      send_cmd(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].stamp,
               dir_rows[i].typed, dir_rows[i].want);
    end

    // zero check interval never fires
    run_phase(32'd1, 32'd0, '1, '1, 120, 16, 3_000_000, 20);
    // default threshold, every visit checked: straddles the limit
    run_phase(32'd1, 32'd1, RstThreshold, RstFreq, 160, 64, 3_000_000, 10);
    // enable bit clear with every other data bit set
    run_phase(32'hFFFF_FFFE, 32'd1, '1, '1, 100, 8, 3_000_000, 20);
    // odd interval, random rate
    run_phase(32'd1, 32'd3, $urandom_range(5000), $urandom_range(32'hEE6B_2800, 1),
              180, 16, 3_000_000, 20);
    // widest interval, zero threshold, slowest counter
    run_phase(32'd1, '1, 32'd0, 32'd1, 100, 8, 3_000_000, 20);
    // reset settings on one region, short visits: shuts off at count 100
    run_phase(32'd1, RstInterval, RstThreshold, RstFreq, 280, 1, 1_000_000, 0);
    // even interval, widest rate, some very long visits
    run_phase(32'd1, 32'd2, '1, '1, 180, 48, 3_000_000, 30);
    // check off again, low settings
    run_phase(32'd0, 32'd1, 32'd0, 32'd1, 200, 16, 3_000_000, 20);

    s_axis_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    // wait out the longest exit path
    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, one long hold-off, a quiet window
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && out_beats >= HoldAfter) begin
        held          = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= steady_window() || $urandom_range(99) >= 38;
    end
  end

  task automatic check_field(input string name, input logic [CountW-1:0] exp_v,
                             input logic [CountW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // compare every result beat with the oldest outstanding expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_beats++;
      got.echo  = m_axis_tdata[IdxW-1:0];
      got.total = m_axis_tdata[IdxW +: CountW];
      got.count = m_axis_tdata[IdxW + CountW +: CountW];
      got.off   = m_axis_tuser[0];
      got.evt   = m_axis_tuser[1];
      got.ign   = m_axis_tuser[2];
      if (pending_totals.size() == 0) begin
        $error("result beat with nothing outstanding, region %0d", got.echo);
        mismatches++;
      end else begin
        want = pending_totals.pop_front();
        check_field("region_echo", CountW'(want.echo), CountW'(got.echo));
        check_field("total_cycles", want.total, got.total);
        check_field("visit_count", want.count, got.count);
        check_field("is_shut_off", CountW'(want.off), CountW'(got.off));
        check_field("shutoff_event", CountW'(want.evt), CountW'(got.evt));
        check_field("ignored", CountW'(want.ign), CountW'(got.ign));
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
